// File: rtl/x86eu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package x86eu_pkg;

  localparam int MEM_ADDR_BITS = 16;
  localparam int ROW_BITS      = MEM_ADDR_BITS - 1;
  localparam int ROWS          = 1 << ROW_BITS;

  localparam int IN_W  = 64;
  localparam int OUT_W = 72;

  localparam logic [2:0] MODE_MOV  = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_CMP  = 3'd3;
  localparam logic [2:0] MODE_JNE  = 3'd4;
  localparam logic [2:0] MODE_LOAD = 3'd6;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_MEM  = 2'd2;
  localparam logic [1:0] KIND_IMM  = 2'd3;

  localparam logic [1:0] PART_LO = 2'd0;
  localparam logic [1:0] PART_HI = 2'd1;

  localparam logic [3:0] REG_BX = 4'd2;
  localparam logic [3:0] REG_BP = 4'd6;
  localparam logic [3:0] REG_SI = 4'd7;
  localparam logic [3:0] REG_DI = 4'd8;
  localparam logic [3:0] REG_IP = 4'd13;
  localparam logic [3:0] REG_LAST = 4'd14;
  localparam int         IP_SLOT = 12;

  typedef logic [MEM_ADDR_BITS-1:0] maddr_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  size;
    logic [1:0]  dk;
    logic [3:0]  dr;
    logic [1:0]  dp;
    logic [1:0]  sk;
    logic [3:0]  sr;
    logic [1:0]  sp;
    logic [3:0]  ab;
    logic [3:0]  ai;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [5:0]  clocks;
  } uop_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_ISSUE, ST_EXEC} bstate_t;

endpackage
`default_nettype wire

// File: rtl/x86eu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module x86eu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/x86eu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module x86eu_front import x86eu_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output      logic            in_tready,
  input  wire logic [IN_W-1:0] in_tdata,
  output      uop_t            head,
  output      logic            head_valid,
  input  wire logic            head_pop
);

  uop_t       dec;
  logic [5:0] base_clk;
  logic [1:0] xfers;
  logic [5:0] ea;
  logic       hb, hi;

  uop_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  // classify: unpack fields and estimate clocks
  always_comb begin
    dec.mode   = in_tdata[2:0];
    dec.size   = in_tdata[5:3];
    dec.dk     = in_tdata[7:6];
    dec.dr     = in_tdata[11:8];
    dec.dp     = in_tdata[13:12];
    dec.sk     = in_tdata[15:14];
    dec.sr     = in_tdata[19:16];
    dec.sp     = in_tdata[21:20];
    dec.ab     = in_tdata[25:22];
    dec.ai     = in_tdata[29:26];
    dec.disp   = in_tdata[45:30];
    dec.imm    = in_tdata[61:46];

    base_clk = 6'd0;
    xfers    = 2'd0;
    unique case ({dec.mode[0], dec.sk, dec.dk})
      {1'b0, KIND_REG, KIND_REG}: base_clk = 6'd2;
      {1'b0, KIND_REG, KIND_MEM}: begin base_clk = 6'd9;  xfers = 2'd1; end
      {1'b0, KIND_MEM, KIND_REG}: begin base_clk = 6'd8;  xfers = 2'd1; end
      {1'b0, KIND_IMM, KIND_REG}: base_clk = 6'd4;
      {1'b0, KIND_IMM, KIND_MEM}: begin base_clk = 6'd10; xfers = 2'd1; end
      {1'b1, KIND_REG, KIND_REG}: base_clk = 6'd3;
      {1'b1, KIND_REG, KIND_MEM}: begin base_clk = 6'd16; xfers = 2'd2; end
      {1'b1, KIND_MEM, KIND_REG}: begin base_clk = 6'd9;  xfers = 2'd1; end
      {1'b1, KIND_IMM, KIND_REG}: base_clk = 6'd4;
      {1'b1, KIND_IMM, KIND_MEM}: begin base_clk = 6'd17; xfers = 2'd2; end
      default: ;
    endcase

    hb = (dec.ab != 4'd0) && (dec.ab <= REG_LAST);
    hi = (dec.ai != 4'd0) && (dec.ai <= REG_LAST);
    ea = 6'd0;
    if (!hb && !hi) begin
      ea = 6'd6;
    end else if (hb && hi) begin
      if ((dec.ab == REG_BP && dec.ai == REG_DI) || (dec.ab == REG_BX && dec.ai == REG_SI)) begin
        ea = 6'd7;
      end else if ((dec.ab == REG_BP && dec.ai == REG_SI) ||
                   (dec.ab == REG_BX && dec.ai == REG_DI)) begin
        ea = 6'd8;
      end
      if (dec.disp != 16'd0) ea = ea + 6'd4;
    end else begin
      ea = (dec.disp == 16'd0) ? 6'd5 : 6'd9;
    end

    dec.clocks = 6'd0;
    if (dec.mode == MODE_MOV || dec.mode == MODE_ADD) begin
      dec.clocks = base_clk;
      if (dec.dk == KIND_MEM || dec.sk == KIND_MEM) begin
        dec.clocks = dec.clocks + ea + (dec.disp[0] ? {2'b00, xfers, 2'b00} : 6'd0);
      end
    end
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head       = q_r[rp_r];
  assign head_valid = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (head_pop) rp_r <= ~rp_r;
      unique case ({push, head_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/x86eu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module x86eu_back import x86eu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire uop_t             head,
  input  wire logic             head_valid,
  output      logic             head_pop,
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  output      logic [OUT_W-1:0] out_tdata
);

  bstate_t state_r, state_nxt;
  logic [ROW_BITS-1:0] clr_r;
  logic [15:0] rf_r [14];
  logic [15:0] rfx [16];
  logic        zf_r, sf_r;
  logic [31:0] total_r;
  uop_t        u_r;
  logic [15:0] addr_r;
  logic        out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [15:0] ip_new, bval, ival, addr, addr_p1;
  maddr_t      ma_lo, ma_hi, ra_lo, ra_hi, lda;
  logic        ev_we, od_we, rd_en;
  logic [ROW_BITS-1:0] ev_wa, od_wa, ev_ra, od_ra;
  logic [7:0]  ev_wd, od_wd, ev_q, od_q;

  logic        go, wide, wr_op, reg_wr, mem_wr, set_flags, jne_taken;
  logic [15:0] mw, dval, sval, dw, sw, res, newword, ip_out;
  logic [16:0] sum;
  logic        zf_n, sf_n;

  always_comb begin
    rfx[0]  = 16'd0;
    rfx[15] = 16'd0;
    for (int i = 0; i < 14; i++) rfx[i+1] = rf_r[i];
  end

  // issue: ip advance and address generation
  always_comb begin
    ip_new  = rf_r[IP_SLOT] + {13'd0, head.size};
    bval    = (head.ab == REG_IP) ? ip_new : rfx[head.ab];
    ival    = (head.ai == REG_IP) ? ip_new : rfx[head.ai];
    addr    = bval + ival + head.disp;
    addr_p1 = addr + 16'd1;
    ma_lo   = maddr_t'(addr);
    ma_hi   = maddr_t'(addr_p1);
    ev_ra   = addr[0] ? ma_hi[MEM_ADDR_BITS-1:1] : ma_lo[MEM_ADDR_BITS-1:1];
    od_ra   = addr[0] ? ma_lo[MEM_ADDR_BITS-1:1] : ma_hi[MEM_ADDR_BITS-1:1];
    head_pop = (state_r == ST_ISSUE) && head_valid;
    rd_en    = head_pop;
  end

  // execute
  always_comb begin
    go   = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
    mw   = addr_r[0] ? {ev_q, od_q} : {od_q, ev_q};
    wide = !(u_r.dk == KIND_REG && (u_r.dp == PART_LO || u_r.dp == PART_HI));
    dw   = rfx[u_r.dr];
    sw   = rfx[u_r.sr];
    unique case (u_r.dk)
      KIND_REG: dval = (u_r.dp == PART_LO) ? {8'd0, dw[7:0]} :
                       (u_r.dp == PART_HI) ? {8'd0, dw[15:8]} : dw;
      KIND_MEM: dval = mw;
      KIND_IMM: dval = u_r.imm;
      default:  dval = 16'd0;
    endcase
    unique case (u_r.sk)
      KIND_REG: sval = (u_r.sp == PART_LO) ? {8'd0, sw[7:0]} :
                       (u_r.sp == PART_HI) ? {8'd0, sw[15:8]} : sw;
      KIND_MEM: sval = mw;
      KIND_IMM: sval = u_r.imm;
      default:  sval = 16'd0;
    endcase

    res = 16'd0;
    wr_op = 1'b0;
    set_flags = 1'b0;
    sum = 17'd0;
    unique case (u_r.mode)
      MODE_MOV: begin res = sval; wr_op = 1'b1; end
      MODE_ADD: begin
        sum = {1'b0, dval} + {1'b0, sval};
        res = sum[15:0]; wr_op = 1'b1; set_flags = 1'b1;
      end
      MODE_SUB: begin res = dval - sval; wr_op = 1'b1; set_flags = 1'b1; end
      MODE_CMP: begin res = dval - sval; set_flags = 1'b1; end
      MODE_LOAD: res = {8'd0, u_r.imm[7:0]};
      default: ;
    endcase
    if (!wide && u_r.mode != MODE_LOAD) res[15:8] = 8'd0;

    zf_n = set_flags ? (res == 16'd0) : zf_r;
    sf_n = set_flags ? (wide ? res[15] : res[7]) : sf_r;

    reg_wr = wr_op && u_r.dk == KIND_REG && u_r.dr != 4'd0 && u_r.dr <= REG_LAST;
    mem_wr = wr_op && u_r.dk == KIND_MEM;
    newword = (u_r.dp == PART_LO) ? {dw[15:8], res[7:0]} :
              (u_r.dp == PART_HI) ? {res[7:0], dw[7:0]} : res;
    jne_taken = (u_r.mode == MODE_JNE) && !zf_r;
    if (reg_wr && u_r.dr == REG_IP) ip_out = newword;
    else if (jne_taken) ip_out = rf_r[IP_SLOT] + u_r.imm;
    else ip_out = rf_r[IP_SLOT];

    // memory write ports: clearing pass, word store or byte load
    ra_lo = maddr_t'(addr_r);
    ra_hi = maddr_t'(addr_r + 16'd1);
    lda   = maddr_t'(u_r.disp);
    ev_we = 1'b0; od_we = 1'b0;
    ev_wa = ra_lo[MEM_ADDR_BITS-1:1]; od_wa = ra_lo[MEM_ADDR_BITS-1:1];
    ev_wd = 8'd0; od_wd = 8'd0;
    if (state_r == ST_CLEAR) begin
      ev_we = 1'b1; od_we = 1'b1;
      ev_wa = clr_r; od_wa = clr_r;
    end else if (go && mem_wr) begin
      ev_we = 1'b1; od_we = 1'b1;
      if (addr_r[0]) begin
        od_wa = ra_lo[MEM_ADDR_BITS-1:1]; od_wd = res[7:0];
        ev_wa = ra_hi[MEM_ADDR_BITS-1:1]; ev_wd = res[15:8];
      end else begin
        ev_wa = ra_lo[MEM_ADDR_BITS-1:1]; ev_wd = res[7:0];
        od_wa = ra_hi[MEM_ADDR_BITS-1:1]; od_wd = res[15:8];
      end
    end else if (go && u_r.mode == MODE_LOAD) begin
      ev_we = !u_r.disp[0]; od_we = u_r.disp[0];
      ev_wa = lda[MEM_ADDR_BITS-1:1]; od_wa = lda[MEM_ADDR_BITS-1:1];
      ev_wd = u_r.imm[7:0]; od_wd = u_r.imm[7:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (&clr_r) state_nxt = ST_ISSUE;
      ST_ISSUE: if (head_valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (go) state_nxt = ST_ISSUE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      zf_r        <= 1'b0;
      sf_r        <= 1'b0;
      total_r     <= 32'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 14; i++) rf_r[i] <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + ROW_BITS'(1);
      if (head_pop) rf_r[IP_SLOT] <= ip_new;
      if (go) begin
        for (int i = 0; i < 14; i++) begin
          if (reg_wr && u_r.dr == 4'(i + 1)) rf_r[i] <= newword;
        end
        if (jne_taken) rf_r[IP_SLOT] <= ip_out;
        zf_r    <= zf_n;
        sf_r    <= sf_n;
        total_r <= total_r + {26'd0, u_r.clocks};
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      u_r    <= head;
      addr_r <= addr;
    end
    if (go) begin
      out_data_r <= {total_r + {26'd0, u_r.clocks}, u_r.clocks, ip_out, sf_n, zf_n, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  x86eu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_even (
    .clk(clk), .we(ev_we), .waddr(ev_wa), .wdata(ev_wd),
    .re(rd_en), .raddr(ev_ra), .rdata(ev_q)
  );

  x86eu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_odd (
    .clk(clk), .we(od_we), .waddr(od_wa), .wdata(od_wd),
    .re(rd_en), .raddr(od_ra), .rdata(od_q)
  );

endmodule
`default_nettype wire

// File: rtl/x86_16_subset_execute_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | signals              | contents
// in_      | slave     | tvalid tready tdata  | one decoded instruction per transfer
// out_     | master    | tvalid tready tdata  | one result per instruction
//
// in the back end each instruction goes through an issue state (ip advance, address
// add, memory read) and then an execute state (alu, register and memory write)
// after reset the data memory is cleared one even/odd byte pair a cycle, through
// all 2^(MEM_ADDR_BITS-1) rows, before the first instruction executes
// a 2-entry queue lets inputs keep arriving while the result register waits on out_tready
module x86_16_subset_execute_unit_top import x86eu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output      logic             in_tready,
  // mode, instr_size, dest_kind, dest_reg, dest_part, src_kind, src_reg,
  // src_part, addr_base, addr_index, displacement, immediate, 2 zero bits
  input  wire logic [IN_W-1:0]  in_tdata,
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  // result_value, zero_flag, sign_flag, ip_value, instr_clocks, clock_total
  output      logic [OUT_W-1:0] out_tdata
);

  uop_t head;
  logic head_valid;
  logic head_pop;

  // front: classify and queue
  x86eu_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .head(head), .head_valid(head_valid), .head_pop(head_pop)
  );

  // back: execute with register file and byte memory
  x86eu_back u_back (
    .clk(clk), .rst_n(rst_n),
    .head(head), .head_valid(head_valid), .head_pop(head_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

// File: tb/x86_16_subset_execute_unit_top_tb.sv
`timescale 1ns / 1ps
module x86_16_subset_execute_unit_top_tb;
  import x86eu_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 450;

  // expected result fields
  typedef struct packed {
    logic [15:0] value;
    logic        zf;
    logic        sf;
    logic [15:0] ip;
    logic [5:0]  clocks;
    logic [31:0] total;
  } exec_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // mode, instr_size, dest_kind, dest_reg, dest_part, src_kind, src_reg,
  // src_part, addr_base, addr_index, displacement, immediate, 2 zero bits
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // result_value, zero_flag, sign_flag, ip_value, instr_clocks, clock_total
  logic [OUT_W-1:0] out_tdata;

  x86_16_subset_execute_unit_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic [15:0] regs_q [14];
  logic        zf_q;
  logic        sf_q;
  logic [7:0]  mem_q [1 << MEM_ADDR_BITS];
  logic [31:0] total_q;

  logic [IN_W-1:0] pending_instrs [$];
  exec_result_t    expected_results [$];

  int  errors;
  int  idle_cycles;
  bit  stim_done;
  bit  calm;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [IN_W-1:0] pack_instr(
    logic [2:0] mode, logic [2:0] size, logic [1:0] dk, logic [3:0] dr, logic [1:0] dp,
    logic [1:0] sk, logic [3:0] sr, logic [1:0] sp, logic [3:0] ab, logic [3:0] ai,
    logic [15:0] disp, logic [15:0] imm);
    logic [IN_W-1:0] d;
    d = '0;
    d[2:0] = mode;   d[5:3] = size;   d[7:6] = dk;   d[11:8] = dr;
    d[13:12] = dp;   d[15:14] = sk;   d[19:16] = sr; d[21:20] = sp;
    d[25:22] = ab;   d[29:26] = ai;   d[45:30] = disp; d[61:46] = imm;
    return d;
  endfunction

  function automatic logic [15:0] reg_read(logic [3:0] r);
    if (r >= 1 && r <= REG_LAST) return regs_q[r - 1];
    return 16'h0;
  endfunction

  function automatic logic [15:0] mem_word_read(logic [15:0] a);
    logic [15:0] a1;
    a1 = a + 16'd1;
    return {mem_q[a1[MEM_ADDR_BITS-1:0]], mem_q[a[MEM_ADDR_BITS-1:0]]};
  endfunction

  function automatic logic [15:0] operand_value(logic [1:0] kind, logic [3:0] r,
      logic [1:0] part, logic [15:0] a, logic [15:0] imm);
    logic [15:0] w;
    case (kind)
      KIND_REG: begin
        w = reg_read(r);
        if (part == PART_LO) return {8'h0, w[7:0]};
        if (part == PART_HI) return {8'h0, w[15:8]};
        return w;
      end
      KIND_MEM: return mem_word_read(a);
      KIND_IMM: return imm;
      default:  return 16'h0;
    endcase
  endfunction

  task automatic operand_store(logic [1:0] kind, logic [3:0] r, logic [1:0] part,
      logic [15:0] a, logic [15:0] v);
    logic [15:0] a1;
    a1 = a + 16'd1;
    if (kind == KIND_REG) begin
      if (r >= 1 && r <= REG_LAST) begin
        if (part == PART_LO)      regs_q[r - 1][7:0]  = v[7:0];
        else if (part == PART_HI) regs_q[r - 1][15:8] = v[7:0];
        else                      regs_q[r - 1]       = v;
      end
    end else if (kind == KIND_MEM) begin
      mem_q[a[MEM_ADDR_BITS-1:0]]  = v[7:0];
      mem_q[a1[MEM_ADDR_BITS-1:0]] = v[15:8];
    end
  endtask

  function automatic int addr_cost(logic [3:0] ab, logic [3:0] ai, logic [15:0] disp);
    bit hb, hi;
    int c;
    hb = ab >= 1 && ab <= REG_LAST;
    hi = ai >= 1 && ai <= REG_LAST;
    c = 0;
    if (!hb && !hi) return 6;
    if (hb && hi) begin
      if (ab == REG_BP)      c = (ai == REG_DI) ? 7 : (ai == REG_SI) ? 8 : 0;
      else if (ab == REG_BX) c = (ai == REG_SI) ? 7 : (ai == REG_DI) ? 8 : 0;
      if (disp != 0) c += 4;
      return c;
    end
    return (disp == 0) ? 5 : 9;
  endfunction

  // base clocks and word transfer counts, indexed by source then destination kind
  function automatic int base_clocks(logic [2:0] mode, logic [1:0] sk, logic [1:0] dk);
    if (mode == MODE_MOV) begin
      if (sk == KIND_REG && dk == KIND_REG) return 2;
      if (sk == KIND_REG && dk == KIND_MEM) return 9;
      if (sk == KIND_MEM && dk == KIND_REG) return 8;
      if (sk == KIND_IMM && dk == KIND_REG) return 4;
      if (sk == KIND_IMM && dk == KIND_MEM) return 10;
    end else begin
      if (sk == KIND_REG && dk == KIND_REG) return 3;
      if (sk == KIND_REG && dk == KIND_MEM) return 16;
      if (sk == KIND_MEM && dk == KIND_REG) return 9;
      if (sk == KIND_IMM && dk == KIND_REG) return 4;
      if (sk == KIND_IMM && dk == KIND_MEM) return 17;
    end
    return 0;
  endfunction

  function automatic int word_xfers(logic [2:0] mode, logic [1:0] sk, logic [1:0] dk);
    if ((sk == KIND_REG || sk == KIND_IMM) && dk == KIND_MEM)
      return (mode == MODE_MOV) ? 1 : 2;
    if (sk == KIND_MEM && dk == KIND_REG) return 1;
    return 0;
  endfunction

  // executes one instruction on the predictor state
  task automatic execute_instr(input logic [IN_W-1:0] d, output exec_result_t r);
    logic [2:0] mode, size;
    logic [1:0] dk, dp, sk, sp;
    logic [3:0] dr, sr, ab, ai;
    logic [15:0] disp, imm, a, v1, v2, res, wmask;
    bit byte_wide;
    int clocks;
    mode = d[2:0];  size = d[5:3];  dk = d[7:6];  dr = d[11:8];  dp = d[13:12];
    sk = d[15:14];  sr = d[19:16];  sp = d[21:20]; ab = d[25:22]; ai = d[29:26];
    disp = d[45:30]; imm = d[61:46];
    byte_wide = (dk == KIND_REG) && (dp < 2);
    wmask = byte_wide ? 16'h00ff : 16'hffff;
    res = 16'h0;
    clocks = 0;
    regs_q[IP_SLOT] = regs_q[IP_SLOT] + 16'(size);
    a = reg_read(ab) + reg_read(ai) + disp;
    case (mode)
      MODE_MOV: begin
        res = operand_value(sk, sr, sp, a, imm) & wmask;
        operand_store(dk, dr, dp, a, res);
      end
      MODE_ADD, MODE_SUB, MODE_CMP: begin
        v1 = operand_value(dk, dr, dp, a, imm);
        v2 = operand_value(sk, sr, sp, a, imm);
        res = ((mode == MODE_ADD) ? v1 + v2 : v1 - v2) & wmask;
        if (mode != MODE_CMP) operand_store(dk, dr, dp, a, res);
        zf_q = (res == 0);
        sf_q = byte_wide ? res[7] : res[15];
      end
      MODE_JNE: if (!zf_q) regs_q[IP_SLOT] = regs_q[IP_SLOT] + imm;
      MODE_LOAD: begin
        res = {8'h0, imm[7:0]};
        mem_q[disp[MEM_ADDR_BITS-1:0]] = imm[7:0];
      end
      default: ;
    endcase
    if (mode == MODE_MOV || mode == MODE_ADD) begin
      clocks = base_clocks(mode, sk, dk);
      if (dk == KIND_MEM || sk == KIND_MEM) begin
        clocks += addr_cost(ab, ai, disp);
        if (disp[0]) clocks += 4 * word_xfers(mode, sk, dk);
      end
      total_q = total_q + 32'(clocks);
    end
    r.value = res; r.zf = zf_q; r.sf = sf_q; r.ip = regs_q[IP_SLOT];
    r.clocks = 6'(clocks); r.total = total_q;
  endtask

  function automatic logic [3:0] pick_reg();
    return 4'($urandom_range(0, 15));
  endfunction

  // stimulus: directed part, then mostly well-formed random instructions
  initial begin
    logic [IN_W-1:0] d;
    logic [2:0] m;
    logic [1:0] dk, sk;
    int n;
    // each register loaded with a distinct value so addressing sees real data
    for (int r = 1; r <= 14; r++)
      pending_instrs.push_back(pack_instr(MODE_MOV, 3'd3, KIND_REG, 4'(r), 2'd2,
                               KIND_IMM, 4'd0, 2'd0, 4'd0, 4'd0, 16'h0, 16'(r * 16'h1111)));
    pending_instrs.push_back(pack_instr(MODE_LOAD, 3'd6, 0, 0, 0, 0, 0, 0, 0, 0,
                                        16'hffff, 16'h80ab));
    pending_instrs.push_back(pack_instr(MODE_ADD, 3'd2, KIND_REG, REG_BX, PART_HI,
                                        KIND_MEM, 0, 0, REG_BP, REG_DI, 16'h0001, 0));
    pending_instrs.push_back(pack_instr(MODE_SUB, 3'd4, KIND_MEM, 0, 0, KIND_REG,
                                        REG_SI, 2'd3, REG_BX, REG_SI, 16'hffff, 0));
    pending_instrs.push_back(pack_instr(MODE_CMP, 3'd1, KIND_REG, 4'd1, PART_LO,
                                        KIND_REG, 4'd1, PART_LO, 0, 0, 0, 0));
    pending_instrs.push_back(pack_instr(MODE_JNE, 3'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                        16'hfff0));
    pending_instrs.push_back(pack_instr(MODE_MOV, 3'd0, KIND_MEM, 0, 0, KIND_MEM, 0, 0,
                                        4'd15, 4'd0, 16'h0000, 16'hffff));
    pending_instrs.push_back(pack_instr(MODE_ADD, 3'd7, KIND_IMM, 4'd15, 2'd3, KIND_NONE,
                                        4'd15, 0, REG_BP, REG_SI, 16'h0002, 16'hffff));
    pending_instrs.push_back(pack_instr(3'd7, 3'd5, KIND_REG, REG_IP, 2'd2, 0, 0, 0,
                                        0, 0, 0, 0));
    pending_instrs.push_back(pack_instr(3'd5, 3'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_instrs.push_back(pack_instr(MODE_JNE, 3'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                        16'h0010));
    n = 0;
    while (n < RANDOM_ITEMS) begin
      d = {$urandom, $urandom};
      d[63:62] = 2'b00;
      if ($urandom_range(0, 9) != 0) begin
        // well-formed operand combinations, register numbers mostly valid
        m = 3'($urandom_range(0, 6));
        dk = 2'($urandom_range(1, 2));
        sk = 2'($urandom_range(1, 3));
        if (dk == KIND_MEM && sk == KIND_MEM) sk = KIND_REG;
        d[2:0] = m; d[7:6] = dk; d[15:14] = sk;
        d[13:12] = 2'($urandom_range(0, 2));
        d[21:20] = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) d[29:26] = 4'd0;
        // keep ip mostly untouched so jumps stay readable
        if (d[11:8] == REG_IP && $urandom_range(0, 1)) d[11:8] = 4'd1;
        if ($urandom_range(0, 3) == 0) d[45:30] = 16'h0;
      end
      pending_instrs.push_back(d);
      n++;
    end
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    exec_result_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        execute_instr(in_tdata, r);
        expected_results.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        // transfer done or nothing offered: choose the next item or an idle cycle
        if (pending_instrs.size() > 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_instrs.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    exec_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = exec_result_t'({out_tdata[15:0], out_tdata[16], out_tdata[17],
                              out_tdata[33:18], out_tdata[39:34], out_tdata[71:40]});
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value)
            $display("%0t: result_value expected %h actual %h", $time, want.value, got.value);
          if (got.zf !== want.zf)
            $display("%0t: zero_flag expected %b actual %b", $time, want.zf, got.zf);
          if (got.sf !== want.sf)
            $display("%0t: sign_flag expected %b actual %b", $time, want.sf, got.sf);
          if (got.ip !== want.ip)
            $display("%0t: ip_value expected %h actual %h", $time, want.ip, got.ip);
          if (got.clocks !== want.clocks)
            $display("%0t: instr_clocks expected %0d actual %0d", $time,
                     want.clocks, got.clocks);
          if (got.total !== want.total)
            $display("%0t: clock_total expected %0d actual %0d", $time,
                     want.total, got.total);
          if (got !== want) errors++;
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // watchdog counts cycles with no transfer on either side
  always @(posedge clk) begin
    cycle_count++;
    // a stretch with no idling on either side
    calm <= (cycle_count % 3000) < 600;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    calm = 1'b0;
    cycle_count = 0;
    zf_q = 1'b0;
    sf_q = 1'b0;
    total_q = '0;
    for (int i = 0; i < 14; i++) regs_q[i] = '0;
    for (int i = 0; i < (1 << MEM_ADDR_BITS); i++) mem_q[i] = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // during the memory clear pass after reset only the queue takes inputs, so the limit covers it
    while (!(stim_done && pending_instrs.size() == 0 && !in_tvalid
             && expected_results.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (errors == 0 && expected_results.size() == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
      $finish;
    end
  end

endmodule
